[sv/gclf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclf_pkg
// Shared types and character constants for the command-line character filter.
// ----------------------------------------------------------------------------
package gclf_pkg;

  localparam int POS_W     = 6;   // width of the position field
  localparam int CNT_MAX_W = 8;   // widest line counter (capacity up to 256)

  typedef enum logic [1:0] {
    EV_CHAR     = 2'd0,
    EV_LINE     = 2'd1,
    EV_EMPTY    = 2'd2,
    EV_OVERFLOW = 2'd3
  } ev_t;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;

  // Decision for one byte, passed from the classifier to the state holder
  typedef struct packed {
    logic             has_res;
    ev_t              ev;
    logic [7:0]       ch;
    logic [POS_W-1:0] pos;
    logic             cnt_clr;
    logic             cnt_inc;
    logic             comment_nxt;
  } step_t;

endpackage

[sv/gclf_classify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclf_classify
// Per-byte classification: comment tracking, dropping, upper-casing and
// line end / overflow decisions against the current line state.
// ----------------------------------------------------------------------------
module gclf_classify
  import gclf_pkg::*;
#(
  parameter int CNT_W    = 6,
  parameter int LINE_CAP = 64
) (
  input  logic [7:0]       rx_byte,
  input  logic [CNT_W-1:0] char_count,
  input  logic             in_comment,
  output step_t            step
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAP - 1);

  logic [CNT_MAX_W-1:0] cnt_ext;
  logic [POS_W-1:0]     cnt_pos;
  logic [7:0]           ch_up;

  assign cnt_ext = CNT_MAX_W'(char_count);
  assign cnt_pos = cnt_ext[POS_W-1:0];
  assign ch_up   = ((rx_byte >= CH_LOW_A) && (rx_byte <= CH_LOW_Z)) ?
                   (rx_byte - CH_LOW_A + CH_UP_A) : rx_byte;

  always_comb begin
    step             = '0;
    step.ev          = EV_CHAR;
    step.comment_nxt = in_comment;
    if ((rx_byte == CH_LF) || (rx_byte == CH_CR)) begin
      step.has_res     = 1'b1;
      step.cnt_clr     = 1'b1;
      step.comment_nxt = 1'b0;
      if (char_count != '0) begin
        step.ev  = EV_LINE;
        step.pos = cnt_pos;
      end else begin
        step.ev  = EV_EMPTY;
      end
    end else if (in_comment) begin
      if (rx_byte == CH_RPAREN) begin
        step.comment_nxt = 1'b0;
      end
    end else if ((rx_byte <= CH_SPACE) || (rx_byte == CH_SLASH)) begin
      // drop whitespace, control bytes and block-delete marks
    end else if (rx_byte == CH_LPAREN) begin
      step.comment_nxt = 1'b1;
    end else if (char_count >= CNT_LAST) begin
      // line full: drop the byte and restart
      step.has_res     = 1'b1;
      step.ev          = EV_OVERFLOW;
      step.cnt_clr     = 1'b1;
      step.comment_nxt = 1'b0;
    end else begin
      step.has_res = 1'b1;
      step.ev      = EV_CHAR;
      step.ch      = ch_up;
      step.pos     = cnt_pos;
      step.cnt_inc = 1'b1;
    end
  end

endmodule

[sv/gcode_line_char_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcode_line_char_filter_core
// Filters a received byte stream into upper-cased command characters with
// their line positions, plus line-complete, empty-line and overflow events.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser
//  in_     | in  | [7:0] rx_byte                          | -
//  out_    | out | [7:0] char_out, [13:8] position, pad   | [1:0] event_res
//
//  One item per cycle sustained while the output is not stalled.
//  Bytes go into an input register, are classified against the line counter
//  and comment flag, and the result lands in the output register.
//  rst_n (synchronous) clears the line counter, comment flag and valids.
//  A stalled output holds its item; bytes that give no result still drain.
// ----------------------------------------------------------------------------
module gcode_line_char_filter_core
  import gclf_pkg::*;
#(
  parameter int LINE_CAP = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] char_out, [13:8] position, [15:14] zero
  output logic [1:0]  out_tuser   // [1:0] event_res
);

  localparam int CNT_W = (LINE_CAP > 2) ? $clog2(LINE_CAP) : 1;

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic [CNT_W-1:0] char_count_r, char_count_nxt;
  logic             in_comment_r;
  logic             out_valid_r;
  ev_t              out_ev_r;
  logic [7:0]       out_ch_r;
  logic [POS_W-1:0] out_pos_r;

  step_t step;
  logic  out_free;
  logic  s1_adv;

  gclf_classify #(
    .CNT_W    (CNT_W),
    .LINE_CAP (LINE_CAP)
  ) u_classify (
    .rx_byte    (s1_byte_r),
    .char_count (char_count_r),
    .in_comment (in_comment_r),
    .step       (step)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!step.has_res || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    char_count_nxt = char_count_r;
    if (step.cnt_clr) begin
      char_count_nxt = '0;
    end else if (step.cnt_inc) begin
      char_count_nxt = char_count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      char_count_r <= '0;
      in_comment_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        char_count_r <= char_count_nxt;
        in_comment_r <= step.comment_nxt;
      end
      // hold the result until taken; load a new one when it advances
      if (s1_adv && step.has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
    if (s1_adv && step.has_res) begin
      out_ev_r  <= step.ev;
      out_ch_r  <= step.ch;
      out_pos_r <= step.pos;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_pos_r, out_ch_r};
  assign out_tuser  = out_ev_r;

endmodule

[tb/sv/gcode_line_char_filter_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcode_line_char_filter_core_tb
// Streams raw bytes into the command-line filter: a short table of directed
// bytes, then random command lines (short, full-length and overflowing) with
// comments, whitespace and noise. A line tracker in the bench predicts the
// results of untyped bytes; results are compared field by field in arrival
// order while both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module gcode_line_char_filter_core_tb
  import gclf_pkg::*;
();

  localparam int LINE_CAP    = 64;
  localparam int RAND_TARGET = 1400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    ev_t              ev;
    logic [7:0]       ch;
    logic [POS_W-1:0] pos;
  } res_t;

  typedef struct packed {
    logic [7:0]       b;
    bit               typed;
    bit               has;
    ev_t              ev;
    logic [7:0]       ch;
    logic [POS_W-1:0] pos;
  } row_t;

  localparam int N_ROWS = 25;
  // typed rows carry their own result; the rest go through the line tracker
  localparam row_t DIR_ROWS [N_ROWS] = '{
    '{8'h0A, 1'b1, 1'b1, EV_EMPTY, 8'h00, 6'd0},  // line feed on an empty line
    '{8'h0D, 1'b1, 1'b1, EV_EMPTY, 8'h00, 6'd0},  // carriage return, empty
    '{8'h61, 1'b1, 1'b1, EV_CHAR,  8'h41, 6'd0},  // 'a' upper-cased
    '{8'h7A, 1'b1, 1'b1, EV_CHAR,  8'h5A, 6'd1},  // 'z' upper-cased
    '{8'hFF, 1'b1, 1'b1, EV_CHAR,  8'hFF, 6'd2},  // high byte kept
    '{8'h7F, 1'b1, 1'b1, EV_CHAR,  8'h7F, 6'd3},
    '{8'h00, 1'b1, 1'b0, EV_CHAR,  8'h00, 6'd0},  // control dropped
    '{8'h20, 1'b1, 1'b0, EV_CHAR,  8'h00, 6'd0},  // space dropped
    '{8'h2F, 1'b1, 1'b0, EV_CHAR,  8'h00, 6'd0},  // slash dropped
    '{8'h29, 1'b0, 1'b0, EV_CHAR,  8'h00, 6'd0},  // stray ')' kept
    '{8'h28, 1'b1, 1'b0, EV_CHAR,  8'h00, 6'd0},  // open comment
    '{8'h67, 1'b1, 1'b0, EV_CHAR,  8'h00, 6'd0},
    '{8'h29, 1'b1, 1'b0, EV_CHAR,  8'h00, 6'd0},  // close comment
    '{8'h78, 1'b0, 1'b0, EV_CHAR,  8'h00, 6'd0},
    '{8'h28, 1'b1, 1'b0, EV_CHAR,  8'h00, 6'd0},
    '{8'hFF, 1'b1, 1'b0, EV_CHAR,  8'h00, 6'd0},
    '{8'h0D, 1'b0, 1'b0, EV_CHAR,  8'h00, 6'd0},  // line end inside a comment
    '{8'h67, 1'b0, 1'b0, EV_CHAR,  8'h00, 6'd0},
    '{8'h28, 1'b1, 1'b0, EV_CHAR,  8'h00, 6'd0},
    '{8'h0A, 1'b0, 1'b0, EV_CHAR,  8'h00, 6'd0},
    '{8'h41, 1'b0, 1'b0, EV_CHAR,  8'h00, 6'd0},
    '{8'h60, 1'b0, 1'b0, EV_CHAR,  8'h00, 6'd0},
    '{8'h7B, 1'b0, 1'b0, EV_CHAR,  8'h00, 6'd0},
    '{8'h01, 1'b1, 1'b0, EV_CHAR,  8'h00, 6'd0},
    '{8'h21, 1'b0, 1'b0, EV_CHAR,  8'h00, 6'd0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  res_t expected_res [$];
  int   line_len   = 0;
  bit   in_cmt     = 1'b0;
  int   n_sent     = 0;
  int   n_checked  = 0;
  int   n_errors   = 0;
  int   cycles     = 0;
  bit   rx_holding = 1'b0;
  int   tx_left    = 0;
  bit   tx_calm    = 1'b0;
  int   rx_left    = 0;
  bit   rx_calm    = 1'b0;

  gcode_line_char_filter_core #(
    .LINE_CAP(LINE_CAP)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("gcode_line_char_filter_core: mismatch");
      $finish;
    end
  end

  // Line tracker: returns 1 when the byte gives a result
  function automatic bit filter_byte(input logic [7:0] b, output res_t r);
    r = '0;
    if (b == CH_LF || b == CH_CR) begin
      r.ev  = (line_len > 0) ? EV_LINE : EV_EMPTY;
      r.pos = (line_len > 0) ? line_len[POS_W-1:0] : '0;
      line_len = 0;
      in_cmt   = 1'b0;
      return 1'b1;
    end
    if (in_cmt) begin
      if (b == CH_RPAREN) in_cmt = 1'b0;
      return 1'b0;
    end
    if (b <= CH_SPACE || b == CH_SLASH) return 1'b0;
    if (b == CH_LPAREN) begin
      in_cmt = 1'b1;
      return 1'b0;
    end
    if (line_len >= LINE_CAP - 1) begin
      r.ev     = EV_OVERFLOW;
      line_len = 0;
      in_cmt   = 1'b0;
      return 1'b1;
    end
    r.ev  = EV_CHAR;
    r.ch  = (b >= CH_LOW_A && b <= CH_LOW_Z) ? b - CH_LOW_A + CH_UP_A : b;
    r.pos = line_len[POS_W-1:0];
    line_len = line_len + 1;
    return 1'b1;
  endfunction

  // Idle cycles for one item: phases of random idling alternate with calm ones
  function automatic int draw_gap(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(20, 80);
      calm = ($urandom_range(0, 2) == 0);
    end
    left = left - 1;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input bit t_has = 1'b0, input res_t t_res = '0);
    int   gap;
    bit   has;
    res_t r;
    gap = draw_gap(tx_left, tx_calm);
    if (rx_holding) gap = 0;  // keep offering while the receiver holds off
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    n_sent++;
    has = filter_byte(b, r);
    if (typed) begin
      has = t_has;
      r   = t_res;
    end
    if (has) begin
      expected_res.push_back(r);
    end
  endtask

  task automatic send_line(input bit long_line);
    int         len;
    int         pick;
    int         n;
    logic [7:0] b;
    len = long_line ? $urandom_range(60, 90) : $urandom_range(0, 20);
    for (int i = 0; i < len; i++) begin
      pick = long_line ? $urandom_range(20, 99) : $urandom_range(0, 99);
      if (pick < 6) begin
        send_byte(CH_LPAREN);
        n = $urandom_range(0, 5);
        for (int k = 0; k < n; k++) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
          send_byte(b);
        end
        // leave some comments open; the line end closes them
        if ($urandom_range(0, 3) != 0) send_byte(CH_RPAREN);
      end else if (pick < 14) begin
        b = ($urandom_range(0, 3) == 0) ? CH_SLASH : 8'($urandom_range(0, 32));
        if (b == CH_LF || b == CH_CR) b = CH_SPACE;
        send_byte(b);
      end else if (pick < 24) begin
        send_byte(8'($urandom_range(33, 255)));
      end else if (pick < 60) begin
        send_byte(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
      end else if (pick < 85) begin
        send_byte(8'($urandom_range(8'h41, 8'h5A)));
      end else begin
        send_byte(8'($urandom_range(8'h2D, 8'h39)));  // digits, '-', '.', '/'
      end
    end
    send_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
  endtask

  // Stimulus
  initial begin
    int kind;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].typed, DIR_ROWS[i].has,
                '{DIR_ROWS[i].ev, DIR_ROWS[i].ch, DIR_ROWS[i].pos});
    end

    n_sent = 0;
    while (n_sent < RAND_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_line(kind < 20);
      end
    end
    in_tvalid <= 1'b0;

    while (expected_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("gcode_line_char_filter_core: match");
    end else begin
      $display("gcode_line_char_filter_core: mismatch");
    end
    $finish;
  end

  // Receiver and result check
  initial begin
    int   gap;
    res_t exp_r;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (n_checked == 200 && !rx_holding) begin
        // hold off long enough for the block to fill and stall its input
        rx_holding = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end else begin
        gap = draw_gap(rx_left, rx_calm);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      n_checked++;
      if (expected_res.size() == 0) begin
        n_errors++;
        $error("unexpected result: event_res %0d char_out 0x%02h position %0d",
               out_tuser, out_tdata[7:0], out_tdata[13:8]);
      end else begin
        exp_r = expected_res.pop_front();
        if (out_tuser !== exp_r.ev) begin
          n_errors++;
          $error("event_res: expected %0d, got %0d", exp_r.ev, out_tuser);
        end
        if (out_tdata[7:0] !== exp_r.ch) begin
          n_errors++;
          $error("char_out: expected 0x%02h, got 0x%02h", exp_r.ch, out_tdata[7:0]);
        end
        if (out_tdata[13:8] !== exp_r.pos) begin
          n_errors++;
          $error("position: expected %0d, got %0d", exp_r.pos, out_tdata[13:8]);
        end
        if (out_tdata[15:14] !== 2'b00) begin
          n_errors++;
          $error("tdata pad: expected 0, got %0d", out_tdata[15:14]);
        end
      end
    end
  end

endmodule

[sim.f]
sv/gclf_pkg.sv
sv/gclf_classify.sv
sv/gcode_line_char_filter_core.sv
tb/sv/gcode_line_char_filter_core_tb.sv
